FILE: src/display_frame_builder_core_macros.svh
// Assertion macros shared by the display frame builder checkers.
`ifndef DISPLAY_FRAME_BUILDER_CORE_MACROS_SVH
`define DISPLAY_FRAME_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dfb_pkg.sv
// ----------------------------------------------------------------------------
// dfb_pkg
// Types, frame constants and the segment table of the display frame builder.
// ----------------------------------------------------------------------------
package dfb_pkg;

    // Fixed frame bytes and limits
    localparam logic [7:0] SYNC_BYTE     = 8'h55;
    localparam logic [7:0] FRAME_ID      = 8'hF0;
    localparam logic [9:0] TEMP_MAX      = 10'd999;
    localparam logic [3:0] FAN_MAX_GRADE = 4'd8;
    localparam int         QUEUE_DEPTH   = 2;

    // Byte positions within the frame
    localparam logic [3:0] IDX_SYNC    = 4'd0;
    localparam logic [3:0] IDX_ID      = 4'd1;
    localparam logic [3:0] IDX_DIG_HI  = 4'd2;
    localparam logic [3:0] IDX_DIG_MID = 4'd3;
    localparam logic [3:0] IDX_DIG_LO  = 4'd4;
    localparam logic [3:0] IDX_LAMP    = 4'd5;
    localparam logic [3:0] IDX_BAR     = 4'd6;
    localparam logic [3:0] IDX_ICON    = 4'd7;
    localparam logic [3:0] IDX_STATUS  = 4'd8;
    localparam logic [3:0] IDX_PAD     = 4'd9;
    localparam logic [3:0] IDX_CSUM    = 4'd10;

    // Panel update request
    typedef struct packed {
        logic [9:0] temp_tenths;
        logic       ignition_on;
        logic       backlight_on;
        logic [3:0] lamp_bits;
        logic [6:0] icon_bits;
        logic [3:0] fan_grade;
    } t_disp_in;

    // One frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_disp_out;

    // Variable frame bytes 2 to 8, handed from front to back
    typedef struct packed {
        logic [7:0] dig_hi;
        logic [7:0] dig_mid;
        logic [7:0] dig_lo;
        logic [7:0] lamp;
        logic [7:0] bar;
        logic [7:0] icon;
        logic [7:0] status;
    } t_frame_body;

    // Seven-segment pattern of one decimal digit
    function automatic logic [7:0] seg7(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'hBE;
            4'd1:    pat = 8'h28;
            4'd2:    pat = 8'hF4;
            4'd3:    pat = 8'hF9;
            4'd4:    pat = 8'h6B;
            4'd5:    pat = 8'hDB;
            4'd6:    pat = 8'hDE;
            4'd7:    pat = 8'hA8;
            4'd8:    pat = 8'hFE;
            4'd9:    pat = 8'hFB;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

FILE: src/dfb_front.sv
// ----------------------------------------------------------------------------
// dfb_front
// Two-stage front end: saturates the temperature, splits it into decimal
// digits, maps lamp, icon and status bits and tracks the fan bar byte.
// ----------------------------------------------------------------------------
module dfb_front
    import dfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_disp_in    i_in_data,
    output logic        o_body_valid,
    input  logic        i_body_ready,
    output t_frame_body o_body
);

    typedef struct packed {
        logic [3:0] hund;
        logic [6:0] rem;
        logic       ign;
        logic       bl;
        logic [3:0] lamps;
        logic [6:0] icons;
        logic [7:0] bar;
    } t_stage_a;

    logic        r_a_valid;
    t_stage_a    r_a;
    logic        r_b_valid;
    t_frame_body r_b;
    logic [7:0]  r_fan_bar;

    logic        in_fire;
    logic        b_free;
    logic        a_move;
    logic [9:0]  temp_sat;
    logic [3:0]  hund;
    logic [6:0]  rem;
    logic [7:0]  n_fan_bar;
    logic [3:0]  tens;
    logic [3:0]  ones;
    t_frame_body body;

    // Stage handshake: each stage moves when the one after it is free
    assign b_free     = !r_b_valid || i_body_ready;
    assign a_move     = r_a_valid && b_free;
    assign o_in_ready = !r_a_valid || b_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // Saturate and take off the hundreds digit by parallel compares
    always_comb begin
        temp_sat = (i_in_data.temp_tenths > TEMP_MAX) ? TEMP_MAX : i_in_data.temp_tenths;
        hund     = 4'd0;
        rem      = temp_sat[6:0];
        for (int k = 1; k <= 9; k++) begin
            if (temp_sat >= 10'(k * 100)) begin
                hund = 4'(k);
                rem  = 7'(temp_sat - 10'(k * 100));
            end
        end
    end

    // Update the fan bar only for a grade in range
    always_comb begin
        if (i_in_data.fan_grade <= FAN_MAX_GRADE) begin
            n_fan_bar = 8'((9'd1 << i_in_data.fan_grade) - 9'd1);
        end else begin
            n_fan_bar = r_fan_bar;
        end
    end

    // Split the remainder into tens and ones, then build the frame body
    always_comb begin
        tens = 4'd0;
        ones = r_a.rem[3:0];
        for (int k = 1; k <= 9; k++) begin
            if (r_a.rem >= 7'(k * 10)) begin
                tens = 4'(k);
                ones = 4'(r_a.rem - 7'(k * 10));
            end
        end
        if (r_a.bl) begin
            body.dig_hi  = seg7(r_a.hund);
            body.dig_mid = seg7(tens) | 8'h01;
            body.dig_lo  = seg7(ones);
        end else begin
            body.dig_hi  = 8'h00;
            body.dig_mid = 8'h00;
            body.dig_lo  = 8'h00;
        end
        body.lamp   = {r_a.lamps[2], r_a.lamps[3], r_a.lamps[0], 2'b00,
                       r_a.lamps[1], 2'b00};
        body.bar    = r_a.bar;
        body.icon   = {r_a.icons[5], r_a.icons[4], r_a.icons[3], r_a.icons[0],
                       r_a.icons[1], 2'b00, r_a.icons[6]};
        body.status = {r_a.icons[2], 4'b0000, r_a.ign, r_a.bl, 1'b0};
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_fan_bar <= 8'h00;
        end else begin
            if (in_fire) begin
                r_a_valid <= 1'b1;
                r_fan_bar <= n_fan_bar;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (i_body_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a.hund  <= hund;
            r_a.rem   <= rem;
            r_a.ign   <= i_in_data.ignition_on;
            r_a.bl    <= i_in_data.backlight_on;
            r_a.lamps <= i_in_data.lamp_bits;
            r_a.icons <= i_in_data.icon_bits;
            r_a.bar   <= n_fan_bar;
        end
        if (a_move) begin
            r_b <= body;
        end
    end

    assign o_body_valid = r_b_valid;
    assign o_body       = r_b;

endmodule

FILE: src/dfb_queue.sv
// ----------------------------------------------------------------------------
// dfb_queue
// Small FIFO of frame bodies between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module dfb_queue
    import dfb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push_valid,
    output logic        o_push_ready,
    input  t_frame_body i_push_data,
    output logic        o_pop_valid,
    input  logic        i_pop_ready,
    output t_frame_body o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame_body             r_mem [DEPTH];
    logic [PTR_W-1:0]        r_wr_ptr;
    logic [PTR_W-1:0]        r_rd_ptr;
    logic [CNT_W-1:0]        r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the request body
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: src/dfb_back.sv
// ----------------------------------------------------------------------------
// dfb_back
// Byte sequencer: walks the eleven frame positions, folds bytes 1 to 9 into
// an end-around-carry sum and emits its complement as the closing byte.
// ----------------------------------------------------------------------------
module dfb_back
    import dfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_body_valid,
    output logic        o_body_ready,
    input  t_frame_body i_body,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_disp_out   o_out_data
);

    logic [3:0] r_idx;
    logic [7:0] r_acc;
    logic       r_out_valid;
    t_disp_out  r_out_data;

    logic       load;
    logic [7:0] cur_byte;
    logic [8:0] sum9;
    logic [7:0] n_acc;

    // Load the output register when a body is available and the register is empty or being taken
    assign load         = i_body_valid && (!r_out_valid || i_out_ready);
    assign o_body_ready = load && (r_idx == IDX_CSUM);

    // Select the byte at the current position
    always_comb begin
        unique case (r_idx)
            IDX_SYNC:    cur_byte = SYNC_BYTE;
            IDX_ID:      cur_byte = FRAME_ID;
            IDX_DIG_HI:  cur_byte = i_body.dig_hi;
            IDX_DIG_MID: cur_byte = i_body.dig_mid;
            IDX_DIG_LO:  cur_byte = i_body.dig_lo;
            IDX_LAMP:    cur_byte = i_body.lamp;
            IDX_BAR:     cur_byte = i_body.bar;
            IDX_ICON:    cur_byte = i_body.icon;
            IDX_STATUS:  cur_byte = i_body.status;
            IDX_PAD:     cur_byte = 8'h00;
            IDX_CSUM:    cur_byte = ~r_acc;
            default:     cur_byte = 8'h00;
        endcase
    end

    // Fold the carry back into the sum
    always_comb begin
        sum9  = {1'b0, r_acc} + {1'b0, cur_byte};
        n_acc = sum9[7:0] + {7'd0, sum9[8]};
    end

    // Sequence positions and accumulate the checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_SYNC;
            r_acc       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (r_idx == IDX_CSUM) begin
                    r_idx <= IDX_SYNC;
                    r_acc <= 8'h00;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx != IDX_SYNC) begin
                        r_acc <= n_acc;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the byte until it is taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data.frame_byte <= cur_byte;
            r_out_data.last_byte  <= (r_idx == IDX_CSUM);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: src/display_frame_builder_core.sv
// ----------------------------------------------------------------------------
// display_frame_builder_core
// Turns panel display updates into 11-byte LIN display frames.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------
//   in      | input     | i_in_valid / o_in_ready  | t_disp_in
//   out     | output    | o_out_valid / i_out_ready| t_disp_out
//
// Each update yields eleven bytes, one per cycle while the frame side is
// ready; the byte sequencer has a single output register.
// The first byte passes the two front stages, the queue and that register.
// Front end, queue and sequencer stall independently; the front keeps
// taking updates while the queue (Q_DEPTH frames) has room.
// Synchronous active-low reset clears the fan bar byte to zero.
// ----------------------------------------------------------------------------
module display_frame_builder_core
    import dfb_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_disp_in  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_disp_out o_out_data
);

    logic        front_valid;
    logic        front_ready;
    t_frame_body front_body;
    logic        back_valid;
    logic        back_ready;
    t_frame_body back_body;

    // Classify updates into frame bodies
    dfb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_body_valid (front_valid),
        .i_body_ready (front_ready),
        .o_body       (front_body)
    );

    // Buffer frame bodies
    dfb_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_body),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_body)
    );

    // Emit frame bytes
    dfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_body_valid (back_valid),
        .o_body_ready (back_ready),
        .i_body       (back_body),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

FILE: src/dfb_checker.sv
// ----------------------------------------------------------------------------
// dfb_checker
// Port-level checks of the frame builder: output hold under stall, frame
// framing by byte position and no output without an outstanding update.
// ----------------------------------------------------------------------------
`include "display_frame_builder_core_macros.svh"

module dfb_checker
    import dfb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_disp_out o_out_data
);

    logic [3:0] r_pos;
    logic [7:0] r_pending;
    logic       in_fire;
    logic       out_fire;
    logic       frame_done;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = o_out_valid && i_out_ready;
    assign frame_done = out_fire && o_out_data.last_byte;

    // Track byte position and updates not yet fully sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= IDX_SYNC;
            r_pending <= 8'd0;
        end else begin
            if (out_fire) begin
                r_pos <= (r_pos == IDX_CSUM) ? IDX_SYNC : r_pos + 1'b1;
            end
            if (in_fire && !frame_done) begin
                r_pending <= r_pending + 1'b1;
            end else if (frame_done && !in_fire) begin
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    `DFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output changed while stalled")
    `DFB_ASSERT_NOW(a_sync_first, i_clk, i_rst_n, out_fire && (r_pos == IDX_SYNC), o_out_data.frame_byte == SYNC_BYTE, "frame does not open with sync")
    `DFB_ASSERT_NOW(a_last_pos, i_clk, i_rst_n, out_fire, o_out_data.last_byte == (r_pos == IDX_CSUM), "last byte flag at wrong position")
    `DFB_ASSERT_NOW(a_no_orphan, i_clk, i_rst_n, o_out_valid, r_pending != 8'd0, "output without an outstanding update")

endmodule

bind display_frame_builder_core dfb_checker u_dfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: dv/display_frame_builder_checker.sv
// ----------------------------------------------------------------------------
// display_frame_builder_checker
// Watches both channels of the display frame builder. Every accepted panel
// request is turned into the eleven frame bytes it must produce. Every
// accepted frame byte is compared with the oldest byte still due.
// ----------------------------------------------------------------------------
module display_frame_builder_checker
    import dfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_disp_in  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_disp_out i_out_data,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Seven-segment patterns, digit 0 in the lowest byte
    localparam logic [79:0] DIGIT_SEGMENTS = 80'hFB_FE_A8_DE_DB_6B_F9_F4_28_BE;
    localparam int          FRAME_BYTES    = 11;

    logic [7:0] fan_bar_q;
    t_disp_out  bytes_due[$];
    t_disp_out  byte_want;

    // Build the frame for one panel request and queue its bytes in order
    task automatic predict_frame(input t_disp_in upd);
        logic [7:0] fb [FRAME_BYTES];
        int         t;
        int         acc;
        t_disp_out  ob;
        t = int'(upd.temp_tenths);
        if (t > int'(TEMP_MAX)) begin
            t = int'(TEMP_MAX);
        end
        fb[IDX_SYNC] = SYNC_BYTE;
        fb[IDX_ID]   = FRAME_ID;
        // Blank all three digits and the decimal point when the backlight is off
        if (upd.backlight_on) begin
            fb[IDX_DIG_HI]  = DIGIT_SEGMENTS[(t / 100) * 8 +: 8];
            fb[IDX_DIG_MID] = DIGIT_SEGMENTS[((t % 100) / 10) * 8 +: 8] | 8'h01;
            fb[IDX_DIG_LO]  = DIGIT_SEGMENTS[(t % 10) * 8 +: 8];
        end else begin
            fb[IDX_DIG_HI]  = 8'h00;
            fb[IDX_DIG_MID] = 8'h00;
            fb[IDX_DIG_LO]  = 8'h00;
        end
        fb[IDX_LAMP] = {upd.lamp_bits[2], upd.lamp_bits[3], upd.lamp_bits[0],
                        2'b00, upd.lamp_bits[1], 2'b00};
        // Hold the previous bar when the grade is out of range
        if (upd.fan_grade <= FAN_MAX_GRADE) begin
            fan_bar_q = 8'((1 << upd.fan_grade) - 1);
        end
        fb[IDX_BAR]    = fan_bar_q;
        fb[IDX_ICON]   = {upd.icon_bits[5], upd.icon_bits[4], upd.icon_bits[3],
                          upd.icon_bits[0], upd.icon_bits[1], 2'b00, upd.icon_bits[6]};
        fb[IDX_STATUS] = {upd.icon_bits[2], 4'b0000, upd.ignition_on,
                          upd.backlight_on, 1'b0};
        fb[IDX_PAD]    = 8'h00;
        // Enhanced checksum: end-around carry sum of bytes 1 to 9, inverted
        acc = 0;
        for (int i = 1; i < 10; i++) begin
            acc += fb[i];
            if (acc > 255) begin
                acc -= 255;
            end
        end
        fb[IDX_CSUM] = ~acc[7:0];
        for (int i = 0; i < FRAME_BYTES; i++) begin
            ob.frame_byte = fb[i];
            ob.last_byte  = (i == int'(IDX_CSUM));
            bytes_due.push_back(ob);
        end
    endtask

    // Compare accepted bytes first, then queue the frame of an accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fan_bar_q = 8'h00;
            bytes_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (bytes_due.size() == 0) begin
                    $error("frame_byte: none expected, actual %02h", i_out_data.frame_byte);
                    o_fail_count++;
                end else begin
                    byte_want = bytes_due.pop_front();
                    if (i_out_data.frame_byte !== byte_want.frame_byte) begin
                        $error("frame_byte: expected %02h, actual %02h",
                               byte_want.frame_byte, i_out_data.frame_byte);
                        o_fail_count++;
                    end
                    if (i_out_data.last_byte !== byte_want.last_byte) begin
                        $error("last_byte: expected %0b, actual %0b",
                               byte_want.last_byte, i_out_data.last_byte);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_frame(i_in_data);
            end
        end
        o_pending = bytes_due.size();
    end

endmodule

FILE: dv/tb_display_frame_builder_core.sv
// ----------------------------------------------------------------------------
// tb_display_frame_builder_core
// Drives panel requests into the display frame builder, directed corners
// first and then random requests, with random gaps on the request side and
// random stalls on the frame side. The checker beside the block predicts
// and compares every frame byte; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_display_frame_builder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dfb_pkg::*;

    localparam int RANDOM_REQUESTS = 230;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    t_disp_in  in_data  = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_disp_out out_data;
    int        fail_count;
    int        pending;
    logic      steady_send = 1'b0;

    display_frame_builder_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    display_frame_builder_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock: 8 ns period
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Frame side: bursts of ready with short stalls and the odd long one
    initial begin
        int run;
        int stall;
        int r;
        @(negedge clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            stall = (r < 15) ? 0 : (r < 88) ? $urandom_range(1, 3)
                                            : $urandom_range(8, 30);
            out_ready <= 1'b1;
            repeat (run) @(negedge clk);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_send) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function automatic t_disp_in panel(input int temp, input bit ign, input bit bl,
                                       input int lamps, input int icons,
                                       input int grade);
        t_disp_in u;
        u.temp_tenths  = 10'(temp);
        u.ignition_on  = ign;
        u.backlight_on = bl;
        u.lamp_bits    = 4'(lamps);
        u.icon_bits    = 7'(icons);
        u.fan_grade    = 4'(grade);
        return u;
    endfunction

    // Mostly in-range temperatures and fan grades, some above range
    function automatic t_disp_in random_update();
        t_disp_in u;
        u.temp_tenths  = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1000, 1023))
                                                     : 10'($urandom_range(0, 999));
        u.ignition_on  = 1'($urandom);
        u.backlight_on = ($urandom_range(0, 4) != 0);
        u.lamp_bits    = 4'($urandom);
        u.icon_bits    = 7'($urandom);
        u.fan_grade    = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                     : 4'($urandom_range(0, 8));
        return u;
    endfunction

    // Present one request, hold it until accepted, return at a falling edge
    task automatic send_update(input t_disp_in upd);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= upd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
    endtask

    // Stimulus and verdict
    initial begin
        t_disp_in directed [$];
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corners: digit extremes, saturation, blanking, bar hold, single bits
        directed = '{
            panel(0,    0, 1, 4'h0, 7'h00, 0),
            panel(999,  1, 1, 4'hF, 7'h7F, 8),
            panel(1023, 1, 1, 4'h0, 7'h00, 15),
            panel(1000, 0, 1, 4'h1, 7'h01, 9),
            panel(123,  1, 1, 4'h2, 7'h02, 1),
            panel(456,  0, 1, 4'h4, 7'h04, 2),
            panel(789,  1, 1, 4'h8, 7'h08, 3),
            panel(890,  0, 1, 4'h0, 7'h10, 4),
            panel(505,  1, 0, 4'h5, 7'h20, 5),
            panel(999,  0, 0, 4'hA, 7'h40, 12),
            panel(64,   1, 1, 4'h0, 7'h00, 6),
            panel(17,   0, 1, 4'hF, 7'h7F, 7),
            panel(300,  1, 0, 4'h0, 7'h00, 0),
            panel(1023, 0, 0, 4'hF, 7'h7F, 8),
            panel(512,  1, 1, 4'h3, 7'h55, 13)
        };
        foreach (directed[i]) begin
            send_update(directed[i]);
        end
        in_valid <= 1'b0;
        wait_drained();

        // Random requests with no-gap stretches and occasional full drains
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 25 == 0) begin
                steady_send = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_REQUESTS / 2 || $urandom_range(0, 39) == 0) begin
                in_valid <= 1'b0;
                wait_drained();
                @(negedge clk);
            end
            send_update(random_update());
        end
        in_valid <= 1'b0;

        // Let trailing bytes show up before the verdict
        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
